// ===== hdl/euler_zyx_vector_rotation_assert.svh =====
// Assertion macros for the ZYX Euler rotation block.
// Defining ASSERT_OFF turns every check into an empty statement.
// Uses no other file.
`ifndef EULER_ZYX_VECTOR_ROTATION_ASSERT_SVH
`define EULER_ZYX_VECTOR_ROTATION_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge, idle in reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, idle in reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== hdl/eulr_pkg.sv =====
// Shared types and constants for the ZYX Euler rotation block.
// No dependencies; used by eulr_plane and euler_zyx_vector_rotation.
`timescale 1ns / 1ps

package eulr_pkg;

    localparam int COORD_W       = 32;
    localparam int COEF_W        = 18;
    localparam int PROD_W        = COORD_W + COEF_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int FRAC_BITS_DEF = 16;

    // Reset value of a cosine register: 1.0 in Q1.16.
    localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd65536;

    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_COS_X = 3'd1,
        REG_SIN_X = 3'd2,
        REG_COS_Y = 3'd3,
        REG_SIN_Y = 3'd4,
        REG_COS_Z = 3'd5,
        REG_SIN_Z = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] cos_x;
        logic signed [COEF_W-1:0] sin_x;
        logic signed [COEF_W-1:0] cos_y;
        logic signed [COEF_W-1:0] sin_y;
        logic signed [COEF_W-1:0] cos_z;
        logic signed [COEF_W-1:0] sin_z;
    } coef_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      sat;
    } point_t;

endpackage

// ===== hdl/eulr_plane.sv =====
// One planar rotation about a selectable axis, two register stages deep.
// Depends on eulr_pkg.
`timescale 1ns / 1ps

module eulr_plane #(
    parameter int FRAC_BITS = eulr_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  eulr_pkg::axis_t axis,
    input  eulr_pkg::coef_t coef,
    input  logic            in_valid,
    output logic            in_ready,
    input  eulr_pkg::point_t in_pt,
    output logic            out_valid,
    input  logic            out_ready,
    output eulr_pkg::point_t out_pt
);
    import eulr_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND =
        {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    // Rounds half up, scales down and clips; the top bit flags a clip.
    function automatic logic [COORD_W:0] round_sat(input logic signed [SUM_W-1:0] acc);
        logic signed [SUM_W-1:0] sh;
        logic [COORD_W:0]        r;
        sh = (acc + ROUND) >>> FRAC_BITS;
        if (sh > SAT_HI) begin
            r = {1'b1, SAT_HI[COORD_W-1:0]};
        end
        else if (sh < SAT_LO) begin
            r = {1'b1, SAT_LO[COORD_W-1:0]};
        end
        else begin
            r = {1'b0, sh[COORD_W-1:0]};
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
        return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    logic signed [COORD_W-1:0] op_a, op_b;
    logic signed [COEF_W-1:0]  op_c, op_s;
    logic                      mid_ready;

    logic                      v1_reg, v1_next;
    logic signed [PROD_W-1:0]  ca_reg, sb_reg, sa_reg, cb_reg;
    point_t                    pt1_reg;
    axis_t                     axis1_reg;

    logic                      v2_reg, v2_next;
    point_t                    pt2_reg, pt2_next;

    logic signed [SUM_W-1:0]   sum_a, sum_b;
    logic [COORD_W:0]          res_a, res_b;

    // Operand routing: the coordinate along the axis passes through.
    always_comb
    begin
        case (axis)
            AXIS_X:
            begin
                op_a = in_pt.y; op_b = in_pt.z; op_c = coef.cos_x; op_s = coef.sin_x;
            end
            AXIS_Y:
            begin
                op_a = in_pt.x; op_b = in_pt.z; op_c = coef.cos_y; op_s = coef.sin_y;
            end
            AXIS_Z:
            begin
                op_a = in_pt.x; op_b = in_pt.y; op_c = coef.cos_z; op_s = coef.sin_z;
            end
            default:
            begin
                op_a = in_pt.x; op_b = in_pt.y; op_c = coef.cos_z; op_s = coef.sin_z;
            end
        endcase
    end

    assign mid_ready = !v2_reg || out_ready;
    assign in_ready  = !v1_reg || mid_ready;
    assign v1_next   = in_ready ? in_valid : v1_reg;
    assign v2_next   = mid_ready ? v1_reg : v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Multiply stage.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            ca_reg    <= op_a * op_c;
            sb_reg    <= op_b * op_s;
            sa_reg    <= op_a * op_s;
            cb_reg    <= op_b * op_c;
            pt1_reg   <= in_pt;
            axis1_reg <= axis;
        end
    end

    // Sum, round and clip stage. About Y the sine enters with the opposite sign.
    always_comb
    begin
        if (axis1_reg == AXIS_Y) begin
            sum_a = ext(ca_reg) + ext(sb_reg);
            sum_b = ext(cb_reg) - ext(sa_reg);
        end
        else begin
            sum_a = ext(ca_reg) - ext(sb_reg);
            sum_b = ext(sa_reg) + ext(cb_reg);
        end
        res_a = round_sat(sum_a);
        res_b = round_sat(sum_b);

        pt2_next     = pt1_reg;
        pt2_next.sat = pt1_reg.sat | res_a[COORD_W] | res_b[COORD_W];
        case (axis1_reg)
            AXIS_X:
            begin
                pt2_next.y = res_a[COORD_W-1:0];
                pt2_next.z = res_b[COORD_W-1:0];
            end
            AXIS_Y:
            begin
                pt2_next.x = res_a[COORD_W-1:0];
                pt2_next.z = res_b[COORD_W-1:0];
            end
            AXIS_Z:
            begin
                pt2_next.x = res_a[COORD_W-1:0];
                pt2_next.y = res_b[COORD_W-1:0];
            end
            default:
            begin
                pt2_next.x = res_a[COORD_W-1:0];
                pt2_next.y = res_b[COORD_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && mid_ready) begin
            pt2_reg <= pt2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_pt    = pt2_reg;

endmodule

// ===== hdl/euler_zyx_vector_rotation.sv =====
// ZYX Euler rotation of signed Q15.16 points. Each item is one point; it is
// rotated through three planar stages using cosines and sines that software
// loads beforehand as signed 18-bit Q1.16 values, so no trigonometry is done
// here. With mode 0 the stages turn about Z, then Y, then X; with mode 1 about
// X, then Y, then Z. Every stage forms its two sums of products exactly, adds
// half an LSB, shifts right by FRAC_BITS and clips to 32 bits; saturated
// reports whether any stage clipped. The block takes one item per clock and
// delivers one result per clock while the output is not stalled. Each of the
// three planar stages registers the products of its four 32x18 multipliers
// and then the output of its adders, rounding and clipping. When the output
// is stalled, the pipeline keeps filling until every stage holds an item, so
// up to six items may be in flight. Configuration registers should only be
// written while no item is in flight.
// Depends on eulr_pkg, eulr_plane and euler_zyx_vector_rotation_assert.svh.
`timescale 1ns / 1ps
`include "euler_zyx_vector_rotation_assert.svh"

module euler_zyx_vector_rotation #(
    parameter int FRAC_BITS = eulr_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_idx,
    input  logic [eulr_pkg::COEF_W-1:0]        cfg_data,
    // Input items.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [eulr_pkg::COORD_W-1:0] coord_x,
    input  logic signed [eulr_pkg::COORD_W-1:0] coord_y,
    input  logic signed [eulr_pkg::COORD_W-1:0] coord_z,
    // Result items.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [eulr_pkg::COORD_W-1:0] rot_x,
    output logic signed [eulr_pkg::COORD_W-1:0] rot_y,
    output logic signed [eulr_pkg::COORD_W-1:0] rot_z,
    output logic                               saturated
);
    import eulr_pkg::*;

    logic   mode_reg, mode_next;
    coef_t  coef_reg, coef_next;

    // Configuration registers. An index beyond the list is ignored.
    always_comb
    begin
        mode_next = mode_reg;
        coef_next = coef_reg;
        if (cfg_we) begin
            case (reg_idx_t'(cfg_idx))
                REG_MODE:  mode_next       = cfg_data[0];
                REG_COS_X: coef_next.cos_x = cfg_data;
                REG_SIN_X: coef_next.sin_x = cfg_data;
                REG_COS_Y: coef_next.cos_y = cfg_data;
                REG_SIN_Y: coef_next.sin_y = cfg_data;
                REG_COS_Z: coef_next.cos_z = cfg_data;
                REG_SIN_Z: coef_next.sin_z = cfg_data;
                default:   mode_next       = mode_reg;
            endcase
        end
    end

    // Reset gives the identity rotation in forward order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= 1'b0;
            coef_reg.cos_x <= COEF_ONE;
            coef_reg.sin_x <= '0;
            coef_reg.cos_y <= COEF_ONE;
            coef_reg.sin_y <= '0;
            coef_reg.cos_z <= COEF_ONE;
            coef_reg.sin_z <= '0;
        end
        else begin
            mode_reg <= mode_next;
            coef_reg <= coef_next;
        end
    end

    // The outer stages swap axes with the mode; the middle one always turns about Y.
    axis_t  axis_first, axis_last;
    assign axis_first = mode_reg ? AXIS_X : AXIS_Z;
    assign axis_last  = mode_reg ? AXIS_Z : AXIS_X;

    point_t pt_in, pt_a, pt_b, pt_out;
    logic   valid_a, ready_a, valid_b, ready_b;

    assign pt_in.x   = coord_x;
    assign pt_in.y   = coord_y;
    assign pt_in.z   = coord_z;
    assign pt_in.sat = 1'b0;

    eulr_plane #(.FRAC_BITS(FRAC_BITS)) u_plane_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .axis      (axis_first),
        .coef      (coef_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_pt     (pt_in),
        .out_valid (valid_a),
        .out_ready (ready_a),
        .out_pt    (pt_a)
    );

    eulr_plane #(.FRAC_BITS(FRAC_BITS)) u_plane_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .axis      (AXIS_Y),
        .coef      (coef_reg),
        .in_valid  (valid_a),
        .in_ready  (ready_a),
        .in_pt     (pt_a),
        .out_valid (valid_b),
        .out_ready (ready_b),
        .out_pt    (pt_b)
    );

    eulr_plane #(.FRAC_BITS(FRAC_BITS)) u_plane_last (
        .clk       (clk),
        .rst_n     (rst_n),
        .axis      (axis_last),
        .coef      (coef_reg),
        .in_valid  (valid_b),
        .in_ready  (ready_b),
        .in_pt     (pt_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pt    (pt_out)
    );

    assign rot_x     = pt_out.x;
    assign rot_y     = pt_out.y;
    assign rot_z     = pt_out.z;
    assign saturated = pt_out.sat;

    // A taken output frees every stage behind it, so the input must be open.
    `ASSERT_IMPLY(a_ready_flows, clk, rst_n, out_ready, in_ready)
    // An empty output register means nothing in the pipeline can be blocked.
    `ASSERT_IMPLY(a_empty_open, clk, rst_n, !out_valid, in_ready)
    // With the output taken and no new item, the first stage is empty next cycle.
    `ASSERT_NEXT(a_bubble_open, clk, rst_n, out_ready && !in_valid, in_ready)

endmodule
